// ===== design/msit_pkg.sv =====
// Shared types and operation codes for the multi-slot interval timer.
package msit_pkg;

  // Operation codes carried in the item's kind field
  localparam logic [3:0] K_TICK     = 4'd0;
  localparam logic [3:0] K_ALLOC    = 4'd1;
  localparam logic [3:0] K_CHANGE   = 4'd2;
  localparam logic [3:0] K_DELETE   = 4'd3;
  localparam logic [3:0] K_RESTART  = 4'd4;
  localparam logic [3:0] K_ENABLE   = 4'd5;
  localparam logic [3:0] K_DISABLE  = 4'd6;
  localparam logic [3:0] K_TOGGLE   = 4'd7;
  localparam logic [3:0] K_EN_ALL   = 4'd8;
  localparam logic [3:0] K_DIS_ALL  = 4'd9;
  localparam logic [3:0] K_QUERY    = 4'd10;

  // One timer slot as held in the slot memory
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] last_time;
    logic [15:0] run_limit;
    logic [15:0] run_count;
    logic        enabled;
    logic [15:0] handler;
    logic [31:0] tag;
    logic        has_param;
  } slot_rec_t;

  // One firing found during a tick scan, held until it is sent
  typedef struct packed {
    logic [3:0]  slot_index;
    logic        deleted;
    logic [15:0] handler;
    logic [31:0] tag;
    logic        has_param;
  } fire_rec_t;

endpackage

// ===== design/msit_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module msit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/msit_rem.sv =====
// Restoring remainder unit: one quotient bit per cycle.
module msit_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [4:0]  step;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[31]};
    diff  = trial - {1'b0, dsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end
endmodule

// ===== design/multi_slot_interval_timer.sv =====
// Top level of the multi-slot interval timer: slot memory, scan sequencer, result stage.
//
//  channel | direction | tdata / tuser / tlast
//  s_*     | in        | tdata: now, slot, period, run_limit, handler, tag, has_param; tuser: kind
//  m_*     | out       | tdata: result fields; tlast: final result of the item
//
// One item at a time. Single-slot operations read and then modify one slot; enable/disable
// all reads and modifies every slot in turn. A tick reads and evaluates every slot; a due
// slot with a nonzero period also waits on the serial remainder unit, and each result is
// then sent. Reset clears all slots at once through valid bits; no clearing pass. A stalled
// output holds the sequencer until taken.
module multi_slot_interval_timer #(
  parameter int SLOT_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] now, [39:32] slot, [71:40] period, [87:72] run_limit,
  // [103:88] handler, [135:104] tag, [136] has_param, rest zero
  input  logic [143:0] s_tdata,
  // [3:0] kind
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] slot_index, [4] ok, [5] fired, [6] deleted, [22:7] fired_handler,
  // [54:23] fired_tag, [55] fired_has_param, [60:56] active_count, rest zero
  output logic [63:0]  m_tdata,
  output logic         m_tlast
);
  import msit_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int SW = $bits(slot_rec_t);
  localparam int FW = $bits(fire_rec_t);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ALLOC  = 4'd1;
  localparam logic [3:0] ST_SRD    = 4'd2;
  localparam logic [3:0] ST_SMOD   = 4'd3;
  localparam logic [3:0] ST_ARD    = 4'd4;
  localparam logic [3:0] ST_AMOD   = 4'd5;
  localparam logic [3:0] ST_TRD    = 4'd6;
  localparam logic [3:0] ST_TEVAL  = 4'd7;
  localparam logic [3:0] ST_TDIV   = 4'd8;
  localparam logic [3:0] ST_TAPPLY = 4'd9;
  localparam logic [3:0] ST_ERD    = 4'd10;
  localparam logic [3:0] ST_EWAIT  = 4'd11;
  localparam logic [3:0] ST_RES    = 4'd12;

  logic [3:0]  state;
  logic [3:0]  kind;
  logic [31:0] now;
  logic [7:0]  slot;
  logic [31:0] period;
  logic [15:0] run_limit;
  logic [15:0] handler;
  logic [31:0] tag;
  logic        has_param;

  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] used;
  logic [CW-1:0]         used_count;
  logic [IW-1:0]         cnt;
  logic [CW-1:0]         nfire;
  logic [CW-1:0]         k;
  logic [31:0]           new_last;
  logic [3:0]            res_idx;
  logic                  res_ok;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_rec_t     ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic          rd_ok;
  slot_rec_t     rd_rec;

  logic          buf_we;
  fire_rec_t     buf_wdata;
  logic          buf_re;
  logic [FW-1:0] buf_rdata;
  fire_rec_t     buf_rec;

  logic          div_start;
  logic          div_done;
  logic [31:0]   div_rem;

  logic [IW-1:0] tgt;
  logic [IW-1:0] free_idx;
  logic          any_free;
  logic          last_slot;
  logic [31:0]   elapsed;
  logic          fire;
  logic [15:0]   cnt_inc;
  logic          del;
  slot_rec_t     free_rec;
  slot_rec_t     mod_rec;
  logic          can_load;
  logic [7:0]    uc8;
  logic [7:0]    idx8;

  assign tgt       = slot[IW-1:0];
  assign last_slot = (cnt == IW'(SLOT_COUNT - 1));
  assign rd_rec    = rd_ok ? slot_rec_t'(ram_rdata) : '0;
  assign buf_rec   = fire_rec_t'(buf_rdata);
  assign elapsed   = now - rd_rec.last_time;
  assign can_load  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign uc8       = 8'(used_count);
  assign idx8      = 8'(cnt);

  // Find the lowest free slot
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IW'(i);
        any_free = 1'b1;
      end
    end
  end

  // Firing decision for the slot under scan
  always_comb begin
    fire    = rd_rec.enabled &&
              (rd_rec.run_limit == 16'd0 || rd_rec.run_count < rd_rec.run_limit);
    cnt_inc = rd_rec.run_count + 16'd1;
    del     = fire && (rd_rec.run_limit != 16'd0) && (cnt_inc >= rd_rec.run_limit);
    free_rec           = '0;
    free_rec.last_time = now;
  end

  // Slot read-modify-write for single-slot operations and enable/disable all
  always_comb begin
    mod_rec = rd_rec;
    unique case (kind)
      K_CHANGE: begin
        if (rd_rec.handler != 16'd0) begin
          mod_rec.period    = period;
          mod_rec.last_time = now;
        end
      end
      K_DELETE: begin
        if (rd_rec.handler != 16'd0) begin
          mod_rec = free_rec;
        end
      end
      K_RESTART: mod_rec.last_time = now;
      K_ENABLE:  mod_rec.enabled = 1'b1;
      K_DISABLE: mod_rec.enabled = 1'b0;
      K_TOGGLE:  mod_rec.enabled = !rd_rec.enabled;
      K_EN_ALL, K_DIS_ALL: begin
        if (rd_rec.handler != 16'd0 && rd_rec.run_count == 16'd0) begin
          mod_rec.enabled = (kind == K_EN_ALL);
        end
      end
      default: mod_rec = rd_rec;
    endcase
  end

  // Memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = mod_rec;
    ram_re    = 1'b0;
    ram_raddr = cnt;
    buf_we    = 1'b0;
    buf_wdata.slot_index = idx8[3:0];
    buf_wdata.deleted    = del;
    buf_wdata.handler    = rd_rec.handler;
    buf_wdata.tag        = rd_rec.tag;
    buf_wdata.has_param  = rd_rec.has_param;
    buf_re    = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_ALLOC: begin
        ram_we    = handler != 16'd0 && any_free;
        ram_waddr = free_idx;
        ram_wdata.period    = period;
        ram_wdata.last_time = now;
        ram_wdata.run_limit = run_limit;
        ram_wdata.run_count = '0;
        ram_wdata.enabled   = 1'b1;
        ram_wdata.handler   = handler;
        ram_wdata.tag       = tag;
        ram_wdata.has_param = has_param;
      end
      ST_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = tgt;
      end
      ST_SMOD: begin
        ram_we    = (kind != K_QUERY);
        ram_waddr = tgt;
      end
      ST_ARD, ST_TRD: ram_re = 1'b1;
      ST_AMOD: ram_we = 1'b1;
      ST_TEVAL: begin
        div_start = (rd_rec.handler != 16'd0) && (elapsed >= rd_rec.period) &&
                    (rd_rec.period != 32'd0);
      end
      ST_TAPPLY: begin
        ram_we = 1'b1;
        if (del) begin
          ram_wdata = free_rec;
        end else begin
          ram_wdata.last_time = new_last;
          if (fire && rd_rec.run_limit != 16'd0) begin
            ram_wdata.run_count = cnt_inc;
          end
        end
        buf_we = fire;
      end
      ST_ERD: buf_re = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  // Sequencer and slot bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      used       <= '0;
      used_count <= '0;
    end else begin
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            priority case (s_tuser)
              K_TICK:   state <= ST_TRD;
              K_ALLOC:  state <= ST_ALLOC;
              K_CHANGE, K_DELETE, K_RESTART, K_ENABLE, K_DISABLE, K_TOGGLE,
              K_QUERY: begin
                state <= ({1'b0, s_tdata[39:32]} < 9'(SLOT_COUNT)) ? ST_SRD : ST_RES;
              end
              K_EN_ALL, K_DIS_ALL: state <= ST_ARD;
              default:  state <= ST_RES;
            endcase
          end
        end
        ST_ALLOC: begin
          if (handler != 16'd0 && any_free) begin
            used[free_idx] <= 1'b1;
            used_count     <= used_count + CW'(1);
          end
          state <= ST_RES;
        end
        ST_SRD: state <= ST_SMOD;
        ST_SMOD: begin
          if (kind == K_DELETE && rd_rec.handler != 16'd0) begin
            used[tgt]  <= 1'b0;
            used_count <= used_count - CW'(1);
          end
          state <= ST_RES;
        end
        ST_ARD: state <= ST_AMOD;
        ST_AMOD: state <= last_slot ? ST_RES : ST_ARD;
        ST_TRD: state <= ST_TEVAL;
        ST_TEVAL: begin
          if (rd_rec.handler == 16'd0 || elapsed < rd_rec.period) begin
            state <= last_slot ? ((nfire == '0) ? ST_RES : ST_ERD) : ST_TRD;
          end else if (rd_rec.period == 32'd0) begin
            state <= ST_TAPPLY;
          end else begin
            state <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            state <= ST_TAPPLY;
          end
        end
        ST_TAPPLY: begin
          if (del) begin
            used[cnt]  <= 1'b0;
            used_count <= used_count - CW'(1);
          end
          if (last_slot) begin
            state <= (nfire == '0 && !fire) ? ST_RES : ST_ERD;
          end else begin
            state <= ST_TRD;
          end
        end
        ST_ERD: state <= ST_EWAIT;
        ST_EWAIT: begin
          if (can_load) begin
            state <= (k == nfire - CW'(1)) ? ST_IDLE : ST_ERD;
          end
        end
        ST_RES: begin
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item fields, counters and pending single result
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= valid[ram_raddr];
    end
    if (state == ST_IDLE && s_tvalid) begin
      kind      <= s_tuser;
      now       <= s_tdata[31:0];
      slot      <= s_tdata[39:32];
      period    <= s_tdata[71:40];
      run_limit <= s_tdata[87:72];
      handler   <= s_tdata[103:88];
      tag       <= s_tdata[135:104];
      has_param <= s_tdata[136];
      cnt       <= '0;
      nfire     <= '0;
      k         <= '0;
      res_idx   <= '0;
      res_ok    <= 1'b0;
    end
    unique case (state)
      ST_ALLOC: begin
        if (handler != 16'd0 && any_free) begin
          res_idx <= 4'(8'(free_idx));
          res_ok  <= 1'b1;
        end
      end
      ST_SMOD: begin
        if (kind == K_CHANGE) begin
          res_ok <= (rd_rec.handler != 16'd0);
        end else if (kind == K_QUERY) begin
          res_ok <= rd_rec.enabled;
        end
      end
      ST_AMOD: cnt <= cnt + IW'(1);
      ST_TEVAL: begin
        new_last <= now;
        if (rd_rec.handler == 16'd0 || elapsed < rd_rec.period) begin
          cnt <= cnt + IW'(1);
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          new_last <= now - div_rem;
        end
      end
      ST_TAPPLY: begin
        cnt <= cnt + IW'(1);
        if (fire) begin
          nfire <= nfire + CW'(1);
        end
      end
      ST_EWAIT: begin
        if (can_load) begin
          k <= k + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load && (state == ST_RES || state == ST_EWAIT)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && state == ST_RES) begin
      m_tdata <= {3'd0, uc8[4:0], 1'b0, 32'd0, 16'd0, 1'b0, 1'b0, res_ok, res_idx};
      m_tlast <= 1'b1;
    end else if (can_load && state == ST_EWAIT) begin
      m_tdata <= {3'd0, uc8[4:0], buf_rec.has_param, buf_rec.tag, buf_rec.handler,
                  buf_rec.deleted, 1'b1, 1'b0, buf_rec.slot_index};
      m_tlast <= (k == nfire - CW'(1));
    end
  end

  msit_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msit_ram #(.WIDTH(FW), .DEPTH(SLOT_COUNT)) u_fire_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (nfire[IW-1:0]),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (k[IW-1:0]),
    .rdata (buf_rdata)
  );

  msit_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (rd_rec.period),
    .done     (div_done),
    .rem      (div_rem)
  );
endmodule

// ===== design/msit_checker.sv =====
// Port-level checks for the multi-slot interval timer, bound to the top level.
module msit_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic         m_tlast
);
  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // Only firing results precede the final one
  a_nonlast_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[5])
    else $error("non-final result is not a firing");

  // A freed slot report is always a firing
  a_del_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> m_tdata[5])
    else $error("deleted without fired");
endmodule

bind multi_slot_interval_timer msit_port_checks u_msit_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== tb/sv/msit_checker.sv =====
// Checker for the interval timer: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module msit_checker
  import msit_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tlast,
  output int           errors,
  output int           pending
);
  localparam int NSLOT = 16;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic        ok;
    logic        fired;
    logic        deleted;
    logic [15:0] fired_handler;
    logic [31:0] fired_tag;
    logic        fired_has_param;
    logic [4:0]  active_count;
    logic        last;
  } timer_result_t;

  slot_rec_t     slots [NSLOT];
  logic [4:0]    used;
  timer_result_t want_q [$];

  assign pending = want_q.size();

  // Model one accepted item and queue its results
  task automatic model_item(input logic [3:0] kind, input logic [143:0] d);
    logic [31:0] now, per, tag, el;
    logic [7:0]  s;
    logic [15:0] lim, hnd;
    logic        hp, ok, inr;
    logic [3:0]  idx;
    timer_result_t r, batch [$];
    logic        fire [NSLOT];
    logic        del [NSLOT];
    slot_rec_t   snap [NSLOT];
    now = d[31:0]; s = d[39:32]; per = d[71:40]; lim = d[87:72];
    hnd = d[103:88]; tag = d[135:104]; hp = d[136];
    inr = s < NSLOT; ok = 0; idx = 0;
    if (kind == K_TICK) begin
      for (int i = 0; i < NSLOT; i++) begin
        fire[i] = 0; del[i] = 0;
        if (slots[i].handler == 0) continue;
        el = now - slots[i].last_time;
        if (el < slots[i].period) continue;
        if (slots[i].period == 0) slots[i].last_time = now;
        else slots[i].last_time += slots[i].period * (el / slots[i].period);
        if (!slots[i].enabled) continue;
        if (slots[i].run_limit == 0) fire[i] = 1;
        else if (slots[i].run_count < slots[i].run_limit) begin
          fire[i] = 1;
          slots[i].run_count++;
          if (slots[i].run_count >= slots[i].run_limit) del[i] = 1;
        end
        snap[i] = slots[i];
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (!fire[i]) continue;
        r = '0;
        r.slot_index = 4'(i); r.fired = 1; r.deleted = del[i];
        r.fired_handler = snap[i].handler; r.fired_tag = snap[i].tag;
        r.fired_has_param = snap[i].has_param;
        batch.push_back(r);
        if (del[i]) begin
          slots[i] = '0; slots[i].last_time = now; used--;
        end
      end
      if (batch.size() == 0) batch.push_back('0);
    end else begin
      case (kind)
        K_ALLOC: if (used < NSLOT && hnd != 0) begin
          for (int i = 0; i < NSLOT; i++) if (slots[i].handler == 0) begin
            slots[i] = '{period: per, last_time: now, run_limit: lim, run_count: 0,
                         enabled: 1, handler: hnd, tag: tag, has_param: hp};
            used++; idx = 4'(i); ok = 1;
            break;
          end
        end
        K_CHANGE: if (inr && slots[s].handler != 0) begin
          slots[s].period = per; slots[s].last_time = now; ok = 1;
        end
        K_DELETE: if (inr && slots[s].handler != 0) begin
          slots[s] = '0; slots[s].last_time = now; used--;
        end
        K_RESTART: if (inr) slots[s].last_time = now;
        K_ENABLE:  if (inr) slots[s].enabled = 1;
        K_DISABLE: if (inr) slots[s].enabled = 0;
        K_TOGGLE:  if (inr) slots[s].enabled = ~slots[s].enabled;
        K_EN_ALL, K_DIS_ALL:
          for (int i = 0; i < NSLOT; i++)
            if (slots[i].handler != 0 && slots[i].run_count == 0)
              slots[i].enabled = (kind == K_EN_ALL);
        K_QUERY: if (inr) ok = slots[s].enabled;
        default: ;
      endcase
      r = '0; r.slot_index = idx; r.ok = ok;
      batch.push_back(r);
    end
    foreach (batch[k]) begin
      batch[k].active_count = used;
      batch[k].last = (k == batch.size() - 1);
      want_q.push_back(batch[k]);
    end
  endtask

  always @(posedge clk) begin
    timer_result_t got, exp;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) slots[i] = '0;
      used = 0;
      errors = 0;
    end else begin
      if (s_tvalid && s_tready) model_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.slot_index = m_tdata[3:0];
        got.ok = m_tdata[4];
        got.fired = m_tdata[5];
        got.deleted = m_tdata[6];
        got.fired_handler = m_tdata[22:7];
        got.fired_tag = m_tdata[54:23];
        got.fired_has_param = m_tdata[55];
        got.active_count = m_tdata[60:56];
        got.last = m_tlast;
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp = want_q.pop_front();
          if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_multi_slot_interval_timer.sv =====
// Top of the interval timer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_multi_slot_interval_timer;
  import msit_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic         m_tlast;
  int           errors, pending;
  int           cycles = 0;
  bit           calm = 0;
  bit           hold_sink = 0;
  logic [31:0]  clock_now = 0;

  always #10 clk = ~clk;

  multi_slot_interval_timer dut (.*);
  msit_checker chk (.*);

  // Limit the run time
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 0;
        for (n = 0; n < 3000; n++) @(posedge clk);
        hold_sink = 0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  // Offer one item and hold it until taken
  task automatic send(input logic [3:0] kind, input logic [31:0] now, input logic [7:0] s,
                      input logic [31:0] per, input logic [15:0] lim,
                      input logic [15:0] hnd, input logic [31:0] tag, input logic hp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= {7'd0, hp, tag, hnd, lim, per, s, now};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic rand_item();
    logic [3:0]  k;
    logic [31:0] per;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) k = K_TICK;
    else if (sel < 58) k = K_ALLOC;
    else if (sel < 97) k = 4'($urandom_range(2, 10));
    else k = 4'($urandom_range(11, 15));
    clock_now += $urandom_range(0, 40);
    per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
    send(k, ($urandom_range(0, 19) == 0) ? $urandom : clock_now,
         8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15)),
         per, ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom_range(0, 4)),
         ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
         $urandom, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: quiet tick, extremes, every operation, full table, range errors
    send(K_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send(K_ALLOC, 0, 0, 5, 0, 0, 32'h1234, 1);
    send(K_ALLOC, 0, 0, 0, 2, 16'hFFFF, 32'hFFFF_FFFF, 1);
    send(K_ALLOC, 0, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h1, 0, 0);
    send(K_TICK, 10, 0, 0, 0, 0, 0, 0);
    send(K_TICK, 11, 0, 0, 0, 0, 0, 0);
    send(K_CHANGE, 12, 1, 3, 0, 0, 0, 0);
    send(K_CHANGE, 12, 8'hFF, 3, 0, 0, 0, 0);
    send(K_CHANGE, 12, 9, 3, 0, 0, 0, 0);
    send(K_QUERY, 12, 1, 0, 0, 0, 0, 0);
    send(K_TOGGLE, 12, 1, 0, 0, 0, 0, 0);
    send(K_QUERY, 12, 1, 0, 0, 0, 0, 0);
    send(K_EN_ALL, 12, 0, 0, 0, 0, 0, 0);
    send(K_DISABLE, 12, 0, 0, 0, 0, 0, 0);
    send(K_ENABLE, 12, 5, 0, 0, 0, 0, 0);
    send(K_RESTART, 32'h8000_0000, 3, 0, 0, 0, 0, 0);
    send(K_DIS_ALL, 12, 0, 0, 0, 0, 0, 0);
    send(K_EN_ALL, 12, 0, 0, 0, 0, 0, 0);
    send(4'd15, 12, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 15; i++) send(K_ALLOC, 20, 0, 0, 0, 16'(i + 2), 32'(i), 1'(i & 1));
    send(K_TICK, 30, 0, 0, 0, 0, 0, 0);
    send(K_DELETE, 31, 0, 0, 0, 0, 0, 0);
    send(K_DELETE, 31, 0, 0, 0, 0, 0, 0);
    send(K_DELETE, 31, 8'd16, 0, 0, 0, 0, 0);
    // Stall the receiver while full ticks keep coming
    hold_sink = 1;
    for (int i = 0; i < 6; i++) send(K_TICK, 32'(40 + i), 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) send(K_DELETE, 50, 8'(i), 0, 0, 0, 0, 0);
    clock_now = 100;
    for (int i = 0; i < 140; i++) begin
      if (i == 110) calm = 1;
      rand_item();
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
